### src/periodic_task_scheduler_defines.svh
// Assertion macros used by the scheduler datapath
`ifndef PERIODIC_TASK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pts_pkg.sv
// Types, constants and codes of the periodic task scheduler
`default_nettype none

package pts_pkg;

  localparam int unsigned OP_W          = 3;
  localparam int unsigned TASK_ID_W     = 16;
  localparam int unsigned RATE_W        = 8;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned TICK_W        = 16;
  localparam int unsigned TICK_FREQ_W   = 16;
  localparam int unsigned MAX_TASKS_W   = 4;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [TICK_FREQ_W-1:0] TICK_FREQ_RST = 16'd1000;
  localparam logic [MAX_TASKS_W-1:0] MAX_TASKS_RST = 4'd8;
  localparam logic [TICK_W-1:0]      TICK_MAX      = 16'hFFFF;

  localparam int unsigned DEF_MAX_TASKS = 8;
  localparam int unsigned DEF_ID_BITS   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_REGISTER   = 3'd1,
    OP_UNREGISTER = 3'd2,
    OP_NOTIFY     = 3'd3,
    OP_BLOCK      = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DISPATCH   = 2'd0,
    KIND_REGISTERED = 2'd1,
    KIND_FULL       = 2'd2,
    KIND_NONE_READY = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_FREQ = 1'd0,
    CFG_MAX_TASKS = 1'd1
  } cfg_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECODE = 2'd1,
    S_TICK   = 2'd2,
    S_SCAN   = 2'd3
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic tick_step;
    logic cnt_clr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic count_zero;
    logic tick_last;
    logic out_free;
    logic scan_last;
  } status_t;

endpackage

`default_nettype wire

### src/pts_ctrl.sv
// Sequencing state machine of the periodic task scheduler
`default_nettype none

module pts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pts_pkg::status_t status_i,
  output pts_pkg::cmd_t    cmd_o
);
  import pts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (status_i.op)
          OP_TICK:     state_d = status_i.count_zero ? S_SCAN : S_TICK;
          OP_REGISTER: state_d = status_i.out_free ? S_IDLE : S_DECODE;
          default:     state_d = S_IDLE;
        endcase
      end
      S_TICK: begin
        if (status_i.tick_last) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.out_free && status_i.scan_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.cnt_clr = 1'b1;
        cmd_o.exec    = (status_i.op == OP_REGISTER) ? status_i.out_free : 1'b1;
      end
      S_TICK: begin
        cmd_o.tick_step = 1'b1;
        cmd_o.cnt_clr   = status_i.tick_last;
      end
      S_SCAN: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/pts_datapath.sv
// Task table, tick walk, dispatch scan and result register of the scheduler
`default_nettype none
`include "periodic_task_scheduler_defines.svh"

module pts_datapath #(
  parameter int unsigned MAX_TASKS = pts_pkg::DEF_MAX_TASKS,
  parameter int unsigned ID_BITS   = pts_pkg::DEF_ID_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [pts_pkg::OP_W-1:0]        op_i,
  input  logic [pts_pkg::TASK_ID_W-1:0]   task_id_i,
  input  logic [pts_pkg::RATE_W-1:0]      rate_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  pts_pkg::cmd_t                   cmd_i,
  output pts_pkg::status_t                status_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pts_pkg::KIND_W-1:0]      kind_o,
  output logic [pts_pkg::TASK_ID_W-1:0]   task_id_res_o,
  output logic                            last_o
);
  import pts_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_TASKS + 1);
  localparam int unsigned IXW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned PRODW = TICK_W + RATE_W + 1;

  logic [TICK_FREQ_W-1:0] tick_freq_q;
  logic [MAX_TASKS_W-1:0] max_tasks_q;

  logic [OP_W-1:0]        op_q;
  logic [TASK_ID_W-1:0]   id_q;
  logic [RATE_W-1:0]      rate_q;

  logic [ID_BITS-1:0]     ids_q   [MAX_TASKS];
  logic [RATE_W-1:0]      rates_q [MAX_TASKS];
  logic [TICK_W-1:0]      ticks_q [MAX_TASKS];
  logic [MAX_TASKS-1:0]   ready_q;
  logic [CW-1:0]          count_q;
  logic [ID_BITS-1:0]     next_id_q;
  logic [CW-1:0]          cnt_q;

  logic                   out_valid_q;
  kind_e                  kind_q;
  logic [TASK_ID_W-1:0]   out_id_q;
  logic                   last_q;

  op_e                    op;
  logic [MAX_TASKS-1:0]   match;
  logic                   found;
  logic [IXW-1:0]         pos;
  logic [IXW-1:0]         cidx;
  logic                   reg_ok;
  logic [MAX_TASKS-1:0]   ready_shift;
  logic [MAX_TASKS-1:0]   count_mask;

  logic [IXW-1:0]         ti;
  logic [TICK_W-1:0]      t_cur;
  logic [RATE_W-1:0]      r_cur;
  logic [TICK_W-1:0]      t_new;
  logic [TICK_W:0]        t_inc1;
  logic [PRODW-1:0]       prod;
  logic                   fire;

  logic [MAX_TASKS-1:0]   pending;
  logic [MAX_TASKS-1:0]   pend_rest;
  logic                   any;
  logic [IXW-1:0]         spos;
  logic                   scan_last;
  logic                   out_free;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    op     = op_e'(op_q);
    cidx   = count_q[IXW-1:0];
    reg_ok = (32'(count_q) < 32'(max_tasks_q)) && (32'(count_q) < MAX_TASKS);
    found  = 1'b0;
    pos    = '0;
    for (int j = 0; j < MAX_TASKS; j++) begin
      match[j]      = (j < int'(count_q)) && (32'(ids_q[j]) == 32'(id_q));
      count_mask[j] = (j < int'(count_q));
    end
    for (int j = MAX_TASKS - 1; j >= 0; j--) begin
      if (match[j]) begin
        found = 1'b1;
        pos   = IXW'(j);
      end
    end
    for (int j = 0; j < MAX_TASKS; j++) begin
      if (j < int'(pos)) begin
        ready_shift[j] = ready_q[j];
      end else if (j + 1 < MAX_TASKS) begin
        ready_shift[j] = ready_q[j+1];
      end else begin
        ready_shift[j] = 1'b0;
      end
    end
  end

  // period test: count >= tick_freq / rate  <=>  (count + 1) * rate > tick_freq
  always_comb begin
    ti     = cnt_q[IXW-1:0];
    t_cur  = ticks_q[ti];
    r_cur  = rates_q[ti];
    t_new  = (t_cur == TICK_MAX) ? t_cur : t_cur + 1'b1;
    t_inc1 = (TICK_W + 1)'(t_new) + 1'b1;
    prod   = PRODW'(t_inc1) * PRODW'(r_cur);
    fire   = (r_cur != '0) && (prod > PRODW'(tick_freq_q));
  end

  always_comb begin
    any  = 1'b0;
    spos = '0;
    for (int j = 0; j < MAX_TASKS; j++) begin
      pending[j] = ready_q[j] && (j >= int'(cnt_q)) && (j < int'(count_q));
    end
    for (int j = MAX_TASKS - 1; j >= 0; j--) begin
      if (pending[j]) begin
        any  = 1'b1;
        spos = IXW'(j);
      end
    end
    pend_rest = pending & (pending - 1'b1);
    scan_last = (pend_rest == '0);
    out_free  = !out_valid_q || out_ready_i;
  end

  assign status_o.op         = op;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.tick_last  = (cnt_q == count_q - 1'b1);
  assign status_o.out_free   = out_free;
  assign status_o.scan_last  = scan_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_freq_q <= TICK_FREQ_RST;
      max_tasks_q <= MAX_TASKS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TICK_FREQ: tick_freq_q <= cfg_data_i[TICK_FREQ_W-1:0];
        CFG_MAX_TASKS: max_tasks_q <= cfg_data_i[MAX_TASKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= '0;
      count_q     <= '0;
      next_id_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        case (op)
          OP_REGISTER: begin
            next_id_q <= next_id_q + 1'b1;
            if (reg_ok) begin
              ready_q[cidx] <= 1'b0;
              count_q       <= count_q + 1'b1;
            end
          end
          OP_UNREGISTER: begin
            if (found) begin
              ready_q <= ready_shift;
              count_q <= count_q - 1'b1;
            end
          end
          OP_NOTIFY: begin
            if (found) ready_q[pos] <= 1'b1;
          end
          OP_BLOCK: begin
            if (found) ready_q[pos] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.tick_step && fire) ready_q[ti] <= 1'b1;
      if (cmd_i.emit && scan_last) ready_q <= '0;

      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.tick_step) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.emit && any) begin
        cnt_q <= CW'(spos) + 1'b1;
      end

      if (cmd_i.emit || (cmd_i.exec && op == OP_REGISTER)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      id_q   <= task_id_i;
      rate_q <= rate_i;
    end
    if (cmd_i.exec && op == OP_REGISTER && reg_ok) begin
      ids_q[cidx]   <= next_id_q;
      rates_q[cidx] <= rate_q;
      ticks_q[cidx] <= '0;
    end
    if (cmd_i.exec && op == OP_UNREGISTER && found) begin
      for (int j = 0; j < MAX_TASKS - 1; j++) begin
        if (j >= int'(pos)) begin
          ids_q[j]   <= ids_q[j+1];
          rates_q[j] <= rates_q[j+1];
          ticks_q[j] <= ticks_q[j+1];
        end
      end
    end
    if (cmd_i.tick_step) ticks_q[ti] <= fire ? '0 : t_new;

    if (cmd_i.emit) begin
      kind_q   <= any ? KIND_DISPATCH : KIND_NONE_READY;
      out_id_q <= any ? TASK_ID_W'(ids_q[spos]) : '0;
      last_q   <= scan_last;
    end else if (cmd_i.exec && op == OP_REGISTER) begin
      kind_q   <= reg_ok ? KIND_REGISTERED : KIND_FULL;
      out_id_q <= TASK_ID_W'(next_id_q);
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign task_id_res_o = out_id_q;
  assign last_o        = last_q;

  `PTS_ASSERT_NEXT(a_reg_grows, clk_i, rst_ni, cmd_i.exec && op == OP_REGISTER && reg_ok, count_q == CW'($past(count_q) + 1'b1), "register did not grow the table")
  `PTS_ASSERT_IMPL(a_ready_in_table, clk_i, rst_ni, 1'b1, (ready_q & ~count_mask) == '0, "ready flag set beyond the table")
  `PTS_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, cmd_i.emit && scan_last, ready_q == '0, "ready flags left after the final dispatch")
  `PTS_ASSERT_IMPL(a_walk_in_table, clk_i, rst_ni, cmd_i.tick_step, cnt_q < count_q, "tick walk beyond the table")

endmodule

`default_nettype wire

### src/periodic_task_scheduler.sv
// Top level of the periodic task scheduler
//
// Input channel (in_valid_i/in_ready_o) takes one command word: op_i, task_id_i, rate_i.
// Output channel (out_valid_o/out_ready_i) returns result words: kind_o,
// task_id_res_o, last_o; last_o marks the final word of a command.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes tick_freq (index 0) or
// max_tasks (index 1) from cfg_data_i; it is always ready.
// One command is worked on at a time; in_ready_o is high only between commands.
// Register, unregister, notify and block are carried out in the decode state; register
// gives one word, loaded there once the output register is free.
// A tick walks the table entries and then scans for ready tasks: one entry per cycle
// goes through the period multiply and compare, then the scan hands out one ready
// task per cycle while the output register is free.
// The output register holds its word while out_ready_i is low; the scan stalls
// behind it, and a new command is accepted while the final word still waits.
// Reset empties the table, clears all ready flags and the id counter, and sets
// tick_freq to 1000 and max_tasks to 8.
`default_nettype none

module periodic_task_scheduler #(
  parameter int unsigned MAX_TASKS = pts_pkg::DEF_MAX_TASKS,
  parameter int unsigned ID_BITS   = pts_pkg::DEF_ID_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pts_pkg::OP_W-1:0]        op_i,
  input  logic [pts_pkg::TASK_ID_W-1:0]   task_id_i,
  input  logic [pts_pkg::RATE_W-1:0]      rate_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pts_pkg::KIND_W-1:0]      kind_o,
  output logic [pts_pkg::TASK_ID_W-1:0]   task_id_res_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import pts_pkg::*;

  cmd_t    cmd;
  status_t status;

  pts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pts_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .ID_BITS   (ID_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_i),
    .task_id_i     (task_id_i),
    .rate_i        (rate_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .task_id_res_o (task_id_res_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

### tb/sv/periodic_task_scheduler_checker.sv
// Checker for the periodic task scheduler: watches the channels, predicts and compares words
`timescale 1ns / 100ps

module periodic_task_scheduler_checker
  import pts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [OP_W-1:0]       op_i,
  input  logic [TASK_ID_W-1:0]  task_id_i,
  input  logic [RATE_W-1:0]     rate_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [TASK_ID_W-1:0]  task_id_res_i,
  input  logic                  last_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    fail_count_o
);

  typedef struct packed {
    kind_e                kind;
    logic [TASK_ID_W-1:0] task_id;
    logic                 last;
  } sched_word_t;

  logic [TASK_ID_W-1:0]   slot_id    [MAX_TASKS];
  logic [RATE_W-1:0]      slot_rate  [MAX_TASKS];
  logic [TICK_W-1:0]      slot_ticks [MAX_TASKS];
  logic [MAX_TASKS-1:0]   slot_ready;
  int unsigned            slot_count;
  logic [TASK_ID_W-1:0]   id_counter;
  logic [TICK_FREQ_W-1:0] tick_freq;
  logic [MAX_TASKS_W-1:0] max_tasks;
  sched_word_t            awaited_words [$];

  task automatic flag_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic void push_word(input kind_e kind, input logic [TASK_ID_W-1:0] id,
                                    input logic last);
    sched_word_t w;
    w.kind    = kind;
    w.task_id = id;
    w.last    = last;
    awaited_words.push_back(w);
  endfunction

  function automatic int find_slot(input logic [TASK_ID_W-1:0] id);
    int i;
    for (i = 0; i < int'(slot_count); i++) begin
      if (slot_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void run_tick();
    int i;
    int final_slot;
    logic [TICK_W-1:0] period;
    final_slot = -1;
    for (i = 0; i < int'(slot_count); i++) begin
      if (slot_ticks[i] != TICK_MAX) slot_ticks[i]++;
      if (slot_rate[i] != '0) begin
        period = tick_freq / slot_rate[i];
        if (slot_ticks[i] >= period) begin
          slot_ready[i] = 1'b1;
          slot_ticks[i] = '0;
        end
      end
    end
    for (i = 0; i < int'(slot_count); i++) begin
      if (slot_ready[i]) final_slot = i;
    end
    for (i = 0; i < int'(slot_count); i++) begin
      if (slot_ready[i]) push_word(KIND_DISPATCH, slot_id[i], i == final_slot);
    end
    if (final_slot < 0) push_word(KIND_NONE_READY, '0, 1'b1);
    slot_ready = '0;
  endfunction

  function automatic void run_register(input logic [RATE_W-1:0] rate);
    int unsigned limit;
    logic [TASK_ID_W-1:0] new_id;
    limit = (max_tasks < MAX_TASKS) ? max_tasks : MAX_TASKS;
    new_id = id_counter;
    id_counter = id_counter + 1'b1;
    if (slot_count < limit) begin
      slot_id[slot_count]    = new_id;
      slot_rate[slot_count]  = rate;
      slot_ticks[slot_count] = '0;
      slot_ready[slot_count] = 1'b0;
      slot_count++;
      push_word(KIND_REGISTERED, new_id, 1'b1);
    end else begin
      push_word(KIND_FULL, new_id, 1'b1);
    end
  endfunction

  function automatic void run_unregister(input logic [TASK_ID_W-1:0] id);
    int pos;
    int i;
    pos = find_slot(id);
    if (pos >= 0) begin
      for (i = pos; i + 1 < int'(slot_count); i++) begin
        slot_id[i]    = slot_id[i+1];
        slot_rate[i]  = slot_rate[i+1];
        slot_ticks[i] = slot_ticks[i+1];
        slot_ready[i] = slot_ready[i+1];
      end
      slot_count--;
      slot_ready[slot_count] = 1'b0;
    end
  endfunction

  function automatic void step_scheduler(input logic [OP_W-1:0] op,
                                         input logic [TASK_ID_W-1:0] id,
                                         input logic [RATE_W-1:0] rate);
    int pos;
    case (op)
      OP_TICK:       run_tick();
      OP_REGISTER:   run_register(rate);
      OP_UNREGISTER: run_unregister(id);
      OP_NOTIFY: begin
        pos = find_slot(id);
        if (pos >= 0) slot_ready[pos] = 1'b1;
      end
      OP_BLOCK: begin
        pos = find_slot(id);
        if (pos >= 0) slot_ready[pos] = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic check_word();
    sched_word_t want;
    if (awaited_words.size() == 0) begin
      flag_mismatch($sformatf("unexpected word: kind %0d id %0d last %0d",
                              kind_i, task_id_res_i, last_i));
    end else begin
      want = awaited_words.pop_front();
      if (kind_i !== want.kind)
        flag_mismatch($sformatf("kind %0d, expected %0d", kind_i, want.kind));
      if (task_id_res_i !== want.task_id)
        flag_mismatch($sformatf("task id %0d, expected %0d", task_id_res_i, want.task_id));
      if (last_i !== want.last)
        flag_mismatch($sformatf("last %0d, expected %0d", last_i, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_TASKS); i++) begin
        slot_id[i]    = '0;
        slot_rate[i]  = '0;
        slot_ticks[i] = '0;
      end
      slot_ready   = '0;
      slot_count   = 0;
      id_counter   = '0;
      tick_freq    = TICK_FREQ_RST;
      max_tasks    = MAX_TASKS_RST;
      awaited_words.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) check_word();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_TICK_FREQ: tick_freq = cfg_data_i;
          CFG_MAX_TASKS: max_tasks = cfg_data_i[MAX_TASKS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) step_scheduler(op_i, task_id_i, rate_i);
      pending_o <= awaited_words.size();
    end
  end

endmodule

### tb/sv/tb_periodic_task_scheduler.sv
// Testbench top for the periodic task scheduler: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_periodic_task_scheduler;
  import pts_pkg::*;

  localparam int          PHASES         = 8;
  localparam int          PHASE_ITEMS    = 52;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_e;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_op      = '0;
  logic [TASK_ID_W-1:0]  in_task_id = '0;
  logic [RATE_W-1:0]     in_rate    = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [KIND_W-1:0]     out_kind;
  logic [TASK_ID_W-1:0]  out_task_id;
  logic                  out_last;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  int                    pending_words;
  int                    fail_count;
  int                    idle_cycles = 0;
  logic [TASK_ID_W-1:0]  ids_issued  = '0;

  logic [TICK_FREQ_W-1:0] phase_tick_freq [PHASES] =
    '{16'd8, 16'd1, 16'hFFFF, 16'd20, 16'd3, 16'd100, 16'd1000, 16'd12};
  logic [MAX_TASKS_W-1:0] phase_max_tasks [PHASES] =
    '{4'd8, 4'd8, 4'd15, 4'd2, 4'd0, 4'd5, 4'd8, 4'd1};

  always #5 clk_i = ~clk_i;

  periodic_task_scheduler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (in_op),
    .task_id_i     (in_task_id),
    .rate_i        (in_rate),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (out_kind),
    .task_id_res_o (out_task_id),
    .last_o        (out_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  periodic_task_scheduler_checker #(
    .MAX_TASKS (DEF_MAX_TASKS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .op_i          (in_op),
    .task_id_i     (in_task_id),
    .rate_i        (in_rate),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .kind_i        (out_kind),
    .task_id_res_i (out_task_id),
    .last_i        (out_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .pending_o     (pending_words),
    .fail_count_o  (fail_count)
  );

  task automatic send_word(input logic [OP_W-1:0] op, input logic [TASK_ID_W-1:0] id,
                           input logic [RATE_W-1:0] rate);
    @(negedge clk_i);
    in_valid   = 1'b1;
    in_op      = op;
    in_task_id = id;
    in_rate    = rate;
    do @(posedge clk_i); while (!in_ready);
    if (op == OP_REGISTER) ids_issued = ids_issued + 1'b1;
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk_i);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (pending_words != 0 || !in_ready) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [TASK_ID_W-1:0] pick_task_id();
    if ($urandom_range(0, 3) == 0) return TASK_ID_W'($urandom);
    return ids_issued - TASK_ID_W'($urandom_range(1, 10));
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return RATE_W'($urandom_range(1, 8));
      default: return RATE_W'($urandom);
    endcase
  endfunction

  task automatic send_random_items(input int count, input bit bursty);
    int sent;
    int burst_left;
    int pick;
    bit drained;
    logic [OP_W-1:0] op;
    sent       = 0;
    drained    = 1'b0;
    burst_left = $urandom_range(1, 12);
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 36)      op = OP_TICK;
      else if (pick < 56) op = OP_REGISTER;
      else if (pick < 68) op = OP_UNREGISTER;
      else if (pick < 80) op = OP_NOTIFY;
      else if (pick < 94) op = OP_BLOCK;
      else                op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      send_word(op, pick_task_id(), pick_rate());
      if (op <= OP_BLOCK) sent++;
      burst_left--;
      if (!drained && sent >= count / 2) begin
        wait_idle();
        drained = 1'b1;
      end else if (burst_left == 0) begin
        if (bursty) pause_sender($urandom_range(1, 8));
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin : receiver
    rx_mode_e   mode;
    int         span;
    logic [7:0] pattern;
    forever begin
      mode    = rx_mode_e'($urandom_range(0, 3));
      span    = $urandom_range(16, 96);
      pattern = 8'($urandom);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          RX_OPEN:    out_ready = 1'b1;
          RX_COIN:    out_ready = 1'($urandom_range(0, 1));
          RX_PATTERN: begin
            out_ready = pattern[0];
            pattern   = {pattern[0], pattern[7:1]};
          end
          default:    out_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int phase;
    logic [CFG_DATA_W-MAX_TASKS_W-1:0] pad;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_TICK_FREQ, 16'd4);
    write_reg(CFG_MAX_TASKS, 16'd3);

    // empty table, then fill past the limit with rate zero, rate above tick frequency,
    // period two
    send_word(OP_TICK, 16'hFFFF, 8'hFF);
    send_word(OP_REGISTER, 16'd0, 8'd0);
    send_word(OP_REGISTER, 16'd0, 8'hFF);
    send_word(OP_REGISTER, 16'd0, 8'd2);
    send_word(OP_REGISTER, 16'd0, 8'd1);
    send_word(OP_TICK, 16'd0, 8'd0);
    send_word(OP_TICK, 16'd0, 8'd0);
    send_word(OP_NOTIFY, 16'd0, 8'd0);
    send_word(OP_TICK, 16'd0, 8'd0);
    send_word(OP_NOTIFY, 16'd2, 8'd0);
    send_word(OP_BLOCK, 16'd2, 8'd0);
    send_word(OP_TICK, 16'd0, 8'd0);
    // unknown ids and spare op codes
    send_word(OP_NOTIFY, 16'hFFFF, 8'd0);
    send_word(OP_BLOCK, 16'hFFFF, 8'd0);
    send_word(OP_UNREGISTER, 16'hFFFF, 8'd0);
    send_word(OP_SPARE_LO, 16'hFFFF, 8'hFF);
    send_word(OP_SPARE_LO + 1'b1, 16'hFFFF, 8'hFF);
    send_word(OP_SPARE_HI, 16'hFFFF, 8'hFF);
    // drop a middle entry while its neighbours are flagged ready
    send_word(OP_NOTIFY, 16'd0, 8'd0);
    send_word(OP_NOTIFY, 16'd2, 8'd0);
    send_word(OP_UNREGISTER, 16'd1, 8'd0);
    send_word(OP_TICK, 16'd0, 8'd0);
    send_word(OP_UNREGISTER, 16'd0, 8'd0);
    send_word(OP_UNREGISTER, 16'd2, 8'd0);
    send_word(OP_TICK, 16'd0, 8'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      pad = (CFG_DATA_W - MAX_TASKS_W)'($urandom);
      write_reg(CFG_TICK_FREQ, phase_tick_freq[phase]);
      write_reg(CFG_MAX_TASKS, {pad, phase_max_tasks[phase]});
      send_random_items(PHASE_ITEMS, phase != 3 && phase != 6);
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
